/* rtl/bbds_pkg.sv */
// bbds_pkg: shared types, codes and constants of the box downscaler
// used by all modules but bbds_ram and bbds_checker, depends on nothing

package bbds_pkg;

    // default store size and the scale ceiling
    localparam int STORE_BYTES_DEF = 1024;
    localparam int MAX_SCALE       = 4;

    // internal widths
    localparam int SCALE_W     = 3;   // saturated scale 0..4
    localparam int SUM_W       = 5;   // box sum 0..16
    localparam int RAW_ADDR_W  = 13;  // unreduced store address, below 5800
    localparam int BASE_W      = 11;  // height * width, below 1906
    localparam int COLSCALE_W  = 9;   // column * scale, below 253
    localparam int QUEUE_DEPTH = 2;

    // constant result bytes for rows outside the window
    localparam logic [7:0] PIX_ALL  = 8'hFF;
    localparam logic [7:0] PIX_NONE = 8'h00;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_HEIGHT_BYTES  = 3'd0,
        CFG_WIDTH_COLUMNS = 3'd1,
        CFG_VERT_OFFSET   = 3'd2,
        CFG_SCALE         = 3'd3,
        CFG_THRESHOLD     = 3'd4,
        CFG_ROW_FIRST     = 3'd5,
        CFG_ROW_LAST      = 3'd6
    } t_cfg_reg;

    // input operation codes
    typedef enum logic {
        OPER_WRITE = 1'b0,
        OPER_QUERY = 1'b1
    } t_operation;

    // job classes handed from front to back
    typedef enum logic [1:0] {
        JOB_WRITE = 2'd0,
        JOB_CONST = 2'd1,
        JOB_QUERY = 2'd2
    } t_job_kind;

    // micro-operations in the back pipeline
    typedef enum logic [1:0] {
        UOP_WRITE = 2'd0,
        UOP_CONST = 2'd1,
        UOP_READ  = 2'd2,
        UOP_FILL  = 2'd3
    } t_uop_kind;

    // back sequencer states
    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_START = 2'd1,
        BK_ISSUE = 2'd2
    } t_back_state;

    // configuration register file
    typedef struct packed {
        logic [3:0]  height_bytes;
        logic [6:0]  width_columns;
        logic [5:0]  vert_offset;
        logic [11:0] scale;
        logic [23:0] threshold;
        logic [8:0]  row_first;
        logic [8:0]  row_last;
    } t_cfg;

    // one classified job in the queue
    typedef struct packed {
        t_job_kind             kind;
        logic [9:0]            addr;
        logic [7:0]            data;
        logic [COLSCALE_W-1:0] colscale;
        logic [SCALE_W-1:0]    scale;
        logic [7:0]            thr;
        logic [7:0]            bit_start;
        logic                  mask;
    } t_job;

    // one micro-operation in the read pipeline
    typedef struct packed {
        t_uop_kind             kind;
        logic [RAW_ADDR_W-1:0] raw;
        logic [7:0]            data;
        logic [2:0]            shift;
        logic [SUM_W-1:0]      fill;
        logic                  first;
        logic                  last;
        logic [2:0]            k;
    } t_uop;

endpackage

/* rtl/bbds_ram.sv */
// bbds_ram: generic single-port RAM with registered read
// standalone, no package dependency

module bbds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bbds_addr_mod.sv */
// bbds_addr_mod: reduces a raw store address modulo the store size
// one register stage, reciprocal multiply and one correction; uses bbds_pkg

module bbds_addr_mod #(
    parameter int STORE_BYTES = bbds_pkg::STORE_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic [bbds_pkg::RAW_ADDR_W-1:0] i_raw,
    output logic [$clog2(STORE_BYTES)-1:0]  o_addr
);

    localparam int RAW_W   = bbds_pkg::RAW_ADDR_W;
    localparam int ADDR_W  = $clog2(STORE_BYTES);
    localparam int RECIP   = (1 << RAW_W) / STORE_BYTES;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
    localparam logic [RAW_W:0]     SB_EXT  = (RAW_W + 1)'(STORE_BYTES);

    logic [RAW_W+RECIP_W-1:0] prod;
    logic [RECIP_W-1:0]       r_q;
    logic [RAW_W-1:0]         r_raw;
    logic [RAW_W:0]           qsb;
    logic [RAW_W:0]           rem1;
    logic [RAW_W:0]           rem;

    // quotient estimate, at most one below the true quotient
    assign prod = (RAW_W + RECIP_W)'(i_raw) * (RAW_W + RECIP_W)'(RECIP_V);

    always_ff @(posedge i_clk) begin
        r_q   <= prod[RAW_W+RECIP_W-1:RAW_W];
        r_raw <= i_raw;
    end

    // remainder with a single correction step
    assign qsb    = (RAW_W + 1)'(r_q) * SB_EXT;
    assign rem1   = {1'b0, r_raw} - qsb;
    assign rem    = (rem1 >= SB_EXT) ? rem1 - SB_EXT : rem1;
    assign o_addr = rem[ADDR_W-1:0];

endmodule

/* rtl/bbds_queue.sv */
// bbds_queue: short job queue between front and back
// flip-flop storage, depth from bbds_pkg

module bbds_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bbds_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output bbds_pkg::t_job o_job,
    output logic           o_empty
);

    localparam int DEPTH = bbds_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_V = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

    bbds_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == DEPTH_V);
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST_P) ? '0 : r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST_P) ? '0 : r_rp + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

/* rtl/bbds_front.sv */
// bbds_front: accepts input words and classifies them into jobs
// selects per-distance scale, threshold and window; uses bbds_pkg

module bbds_front (
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_full,
    input  bbds_pkg::t_cfg i_cfg,
    input  logic           i_operation,
    input  logic [9:0]     i_store_address,
    input  logic [7:0]     i_store_data,
    input  logic [5:0]     i_column,
    input  logic [2:0]     i_out_row,
    input  logic [1:0]     i_distance,
    input  logic           i_use_mask,
    output logic           o_push,
    output bbds_pkg::t_job o_job
);

    localparam int SCALE_W = bbds_pkg::SCALE_W;
    localparam int CS_W    = bbds_pkg::COLSCALE_W;

    logic [3:0]         nib;
    logic [7:0]         thr;
    logic [2:0]         row_first;
    logic [2:0]         row_last;
    logic [SCALE_W-1:0] scale;
    logic               no_window;
    logic [2:0]         row_off;
    logic [5:0]         row_prod;

    // per-distance field select
    always_comb begin
        unique case (i_distance)
            2'd1: begin
                nib       = i_cfg.scale[3:0];
                thr       = i_cfg.threshold[7:0];
                row_first = i_cfg.row_first[2:0];
                row_last  = i_cfg.row_last[2:0];
            end
            2'd2: begin
                nib       = i_cfg.scale[7:4];
                thr       = i_cfg.threshold[15:8];
                row_first = i_cfg.row_first[5:3];
                row_last  = i_cfg.row_last[5:3];
            end
            2'd3: begin
                nib       = i_cfg.scale[11:8];
                thr       = i_cfg.threshold[23:16];
                row_first = i_cfg.row_first[8:6];
                row_last  = i_cfg.row_last[8:6];
            end
            default: begin
                nib       = '0;
                thr       = '0;
                row_first = '0;
                row_last  = '0;
            end
        endcase
    end

    // saturated scale and window check
    assign scale = (nib > 4'(bbds_pkg::MAX_SCALE)) ? SCALE_W'(bbds_pkg::MAX_SCALE)
                                                   : nib[SCALE_W-1:0];
    assign no_window = (i_distance == 2'd0) || (i_out_row < row_first)
                       || (i_out_row > row_last);
    assign row_off   = i_out_row - row_first;
    assign row_prod  = 6'(row_off) * 6'(scale);

    // job build
    always_comb begin
        o_job           = '0;
        o_job.addr      = i_store_address;
        o_job.colscale  = CS_W'(i_column) * CS_W'(scale);
        o_job.scale     = scale;
        o_job.thr       = thr;
        o_job.bit_start = {row_prod[4:0], 3'b000};
        o_job.mask      = i_use_mask;
        if (i_operation == bbds_pkg::OPER_WRITE) begin
            o_job.kind = bbds_pkg::JOB_WRITE;
            o_job.data = i_store_data;
        end else begin
            o_job.kind = no_window ? bbds_pkg::JOB_CONST : bbds_pkg::JOB_QUERY;
            o_job.data = i_use_mask ? bbds_pkg::PIX_ALL : bbds_pkg::PIX_NONE;
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule

/* rtl/bbds_back.sv */
// bbds_back: sequencer and read pipeline that carries out jobs
// issues one store access a cycle, sums boxes, thresholds and holds results;
// uses bbds_pkg, bbds_addr_mod and bbds_ram

module bbds_back #(
    parameter int STORE_BYTES = bbds_pkg::STORE_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bbds_pkg::t_cfg i_cfg,
    input  bbds_pkg::t_job i_job,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_pixels
);

    localparam int ADDR_W  = $clog2(STORE_BYTES);
    localparam int RAW_W   = bbds_pkg::RAW_ADDR_W;
    localparam int SCALE_W = bbds_pkg::SCALE_W;
    localparam int SUM_W   = bbds_pkg::SUM_W;
    localparam int BASE_W  = bbds_pkg::BASE_W;
    localparam int CS_W    = bbds_pkg::COLSCALE_W;

    function automatic logic [2:0] count4(input logic [3:0] v);
        logic [2:0] n;
        n = '0;
        for (int i = 0; i < 4; i++) begin
            n = n + 3'(v[i]);
        end
        return n;
    endfunction

    bbds_pkg::t_back_state r_state, n_state;

    logic [BASE_W-1:0]  r_base;
    logic [RAW_W-1:0]   r_start, n_start;
    logic [RAW_W-1:0]   r_addr, n_addr;
    logic [7:0]         r_bit, n_bit;
    logic [2:0]         r_k, n_k;
    logic [2:0]         r_c, n_c;
    logic               r_busy, n_busy;
    logic [CS_W-1:0]    r_colscale;
    logic [SCALE_W-1:0] r_scale;
    logic               r_mask;
    logic [7:0]         r_thr;
    logic [3:0]         r_bitmask;
    logic [SUM_W-1:0]   r_sqr;

    logic            res_free;
    logic            load_query;
    logic            emit;
    bbds_pkg::t_uop  n_uop;
    logic [7:0]      end_bit;
    logic [7:0]      bit_rel;
    logic            in_win;
    logic            do_read;
    logic            last_c;
    logic            adv_k;
    logic [RAW_W-1:0] raw_first;
    logic [RAW_W-1:0] raw_next;

    logic            r_p0_valid, r_p1_valid, r_p2_valid;
    bbds_pkg::t_uop  r_p0, r_p1, r_p2;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]      ram_rdata;
    logic            ram_we;

    logic [7:0]       shifted;
    logic [SUM_W-1:0] contrib;
    logic [SUM_W-1:0] sum_now;
    logic [SUM_W-1:0] r_sum;
    logic             p2_acc;
    logic             pix_bit;
    logic [7:0]       r_pix, n_pix;
    logic             p2_result;
    logic [7:0]       res_value;
    logic             r_res_valid;
    logic [7:0]       r_res;
    logic             r_out_valid;
    logic [7:0]       r_out;
    logic             load_out;

    // mask plane base, follows configuration
    always_ff @(posedge i_clk) begin
        r_base <= BASE_W'(i_cfg.height_bytes) * BASE_W'(i_cfg.width_columns);
    end

    // a result job starts only with nothing in flight and the hold slot free
    assign res_free   = !r_busy && !r_res_valid;
    assign load_query = (r_state == bbds_pkg::BK_IDLE) && !i_empty
                        && (i_job.kind == bbds_pkg::JOB_QUERY) && res_free;

    // window and address terms of the current output bit
    assign end_bit   = 8'({2'b00, i_cfg.vert_offset} + {1'b0, i_cfg.height_bytes, 3'b000});
    assign bit_rel   = r_bit - {2'b00, i_cfg.vert_offset};
    assign in_win    = (r_bit >= {2'b00, i_cfg.vert_offset}) && (r_bit < end_bit);
    assign do_read   = in_win && (r_scale != '0);
    assign last_c    = (r_c == r_scale - SCALE_W'(1));
    assign adv_k     = (r_state == bbds_pkg::BK_ISSUE) && (!do_read || last_c);
    assign raw_first = r_start + RAW_W'(bit_rel[7:3]);
    assign raw_next  = r_addr + RAW_W'(i_cfg.height_bytes);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bbds_pkg::BK_IDLE: begin
                if (load_query) begin
                    n_state = bbds_pkg::BK_START;
                end
            end
            bbds_pkg::BK_START: begin
                n_state = bbds_pkg::BK_ISSUE;
            end
            bbds_pkg::BK_ISSUE: begin
                if (adv_k && (r_k == 3'd7)) begin
                    n_state = bbds_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = bbds_pkg::BK_IDLE;
            end
        endcase
    end

    // sequencer outputs and counters
    always_comb begin
        o_pop   = 1'b0;
        emit    = 1'b0;
        n_uop   = '0;
        n_busy  = r_busy;
        n_start = r_start;
        n_addr  = r_addr;
        n_bit   = r_bit;
        n_k     = r_k;
        n_c     = r_c;
        if (p2_result) begin
            n_busy = 1'b0;
        end
        unique case (r_state)
            bbds_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    unique case (i_job.kind)
                        bbds_pkg::JOB_WRITE: begin
                            o_pop      = 1'b1;
                            emit       = 1'b1;
                            n_uop.kind = bbds_pkg::UOP_WRITE;
                            n_uop.raw  = RAW_W'(i_job.addr);
                            n_uop.data = i_job.data;
                        end
                        bbds_pkg::JOB_CONST: begin
                            if (res_free) begin
                                o_pop      = 1'b1;
                                emit       = 1'b1;
                                n_busy     = 1'b1;
                                n_uop.kind = bbds_pkg::UOP_CONST;
                                n_uop.data = i_job.data;
                            end
                        end
                        bbds_pkg::JOB_QUERY: begin
                            if (res_free) begin
                                o_pop  = 1'b1;
                                n_busy = 1'b1;
                                n_bit  = i_job.bit_start;
                                n_k    = '0;
                                n_c    = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            bbds_pkg::BK_START: begin
                n_start = (r_mask ? RAW_W'(r_base) : '0)
                          + RAW_W'(r_colscale) * RAW_W'(i_cfg.height_bytes);
            end
            bbds_pkg::BK_ISSUE: begin
                emit        = 1'b1;
                n_uop.k     = r_k;
                n_uop.shift = r_bit[2:0];
                if (do_read) begin
                    n_uop.kind  = bbds_pkg::UOP_READ;
                    n_uop.raw   = (r_c == '0) ? raw_first : raw_next;
                    n_uop.first = (r_c == '0);
                    n_uop.last  = last_c;
                    n_addr      = n_uop.raw;
                    if (!last_c) begin
                        n_c = r_c + 3'd1;
                    end
                end else begin
                    n_uop.kind  = bbds_pkg::UOP_FILL;
                    n_uop.fill  = (r_mask && !in_win) ? r_sqr : '0;
                    n_uop.first = 1'b1;
                    n_uop.last  = 1'b1;
                end
                if (adv_k) begin
                    n_c   = '0;
                    n_bit = r_bit + 8'(r_scale);
                    n_k   = r_k + 3'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbds_pkg::BK_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_addr  <= n_addr;
        r_bit   <= n_bit;
        r_k     <= n_k;
        r_c     <= n_c;
    end

    // query parameters, held for the whole query
    always_ff @(posedge i_clk) begin
        if (load_query) begin
            r_colscale <= i_job.colscale;
            r_scale    <= i_job.scale;
            r_mask     <= i_job.mask;
            r_thr      <= i_job.thr;
            r_bitmask  <= 4'((5'd1 << i_job.scale) - 5'd1);
            r_sqr      <= SUM_W'(i_job.scale) * SUM_W'(i_job.scale);
        end
    end

    // pipeline: issue, address reduce, store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_valid <= 1'b0;
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            r_p0_valid <= emit;
            r_p1_valid <= r_p0_valid;
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0 <= n_uop;
        r_p1 <= r_p0;
        r_p2 <= r_p1;
    end

    bbds_addr_mod #(
        .STORE_BYTES(STORE_BYTES)
    ) u_mod (
        .i_clk  (i_clk),
        .i_raw  (r_p0.raw),
        .o_addr (ram_addr)
    );

    assign ram_we = r_p1_valid && (r_p1.kind == bbds_pkg::UOP_WRITE);

    bbds_ram #(
        .WIDTH(8),
        .DEPTH(STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_p1.data),
        .o_rdata (ram_rdata)
    );

    // box sum and threshold
    assign shifted = ram_rdata >> r_p2.shift;
    always_comb begin
        case (r_p2.kind)
            bbds_pkg::UOP_READ: contrib = SUM_W'(count4(shifted[3:0] & r_bitmask));
            bbds_pkg::UOP_FILL: contrib = r_p2.fill;
            default:            contrib = '0;
        endcase
    end

    assign p2_acc  = r_p2_valid && ((r_p2.kind == bbds_pkg::UOP_READ)
                                    || (r_p2.kind == bbds_pkg::UOP_FILL));
    assign sum_now = (r_p2.first ? '0 : r_sum) + contrib;
    assign pix_bit = (8'(sum_now) >= r_thr);

    always_comb begin
        n_pix = r_pix;
        n_pix[r_p2.k] = pix_bit;
    end

    assign p2_result = r_p2_valid && ((r_p2.kind == bbds_pkg::UOP_CONST)
                       || (p2_acc && r_p2.last && (r_p2.k == 3'd7)));
    assign res_value = (r_p2.kind == bbds_pkg::UOP_CONST) ? r_p2.data : n_pix;

    always_ff @(posedge i_clk) begin
        if (p2_acc) begin
            r_sum <= sum_now;
            if (r_p2.last) begin
                r_pix <= n_pix;
            end
        end
    end

    // result hold slot and output register
    assign load_out = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= r_res_valid;
            end
            if (p2_result) begin
                r_res_valid <= 1'b1;
            end else if (load_out) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p2_result) begin
            r_res <= res_value;
        end
        if (load_out) begin
            r_out <= r_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_pixels = r_out;

endmodule

/* rtl/bitmap_box_downscale_threshold.sv */
// bitmap_box_downscale_threshold: top level, configuration registers and wiring
// uses bbds_pkg, bbds_front, bbds_queue and bbds_back
//
//  channel   direction  handshake                  payload
//  input     in         i_valid / o_ready          i_operation .. i_use_mask
//  result    out        o_valid / i_ready          o_pixels
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// a store write gives no result
// a query in its window is popped, set up, then issued as one store read per box column
// of each output bit, or one fill for each output bit without reads
// a query outside its window or at distance zero gives a constant byte without store reads
// a result word passes the pipeline registers, hold slot and output register; the next
// query waits for the hold slot to empty; a two-entry job queue takes input meanwhile
// synchronous active-low reset clears control; the store is not cleared

module bitmap_box_downscale_threshold #(
    parameter int STORE_BYTES = bbds_pkg::STORE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [9:0]  i_store_address,
    input  logic [7:0]  i_store_data,
    input  logic [5:0]  i_column,
    input  logic [2:0]  i_out_row,
    input  logic [1:0]  i_distance,
    input  logic        i_use_mask,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_pixels,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    bbds_pkg::t_cfg r_cfg;
    bbds_pkg::t_job front_job;
    bbds_pkg::t_job head_job;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.height_bytes  <= 4'd1;
            r_cfg.width_columns <= 7'd1;
            r_cfg.vert_offset   <= '0;
            r_cfg.scale         <= '0;
            r_cfg.threshold     <= '0;
            r_cfg.row_first     <= '0;
            r_cfg.row_last      <= '0;
        end else if (i_cfg_valid) begin
            unique case (bbds_pkg::t_cfg_reg'(i_cfg_index))
                bbds_pkg::CFG_HEIGHT_BYTES:  r_cfg.height_bytes  <= i_cfg_data[3:0];
                bbds_pkg::CFG_WIDTH_COLUMNS: r_cfg.width_columns <= i_cfg_data[6:0];
                bbds_pkg::CFG_VERT_OFFSET:   r_cfg.vert_offset   <= i_cfg_data[5:0];
                bbds_pkg::CFG_SCALE:         r_cfg.scale         <= i_cfg_data[11:0];
                bbds_pkg::CFG_THRESHOLD:     r_cfg.threshold     <= i_cfg_data;
                bbds_pkg::CFG_ROW_FIRST:     r_cfg.row_first     <= i_cfg_data[8:0];
                bbds_pkg::CFG_ROW_LAST:      r_cfg.row_last      <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // front: accept and classify
    bbds_front u_front (
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_full          (full),
        .i_cfg           (r_cfg),
        .i_operation     (i_operation),
        .i_store_address (i_store_address),
        .i_store_data    (i_store_data),
        .i_column        (i_column),
        .i_out_row       (i_out_row),
        .i_distance      (i_distance),
        .i_use_mask      (i_use_mask),
        .o_push          (push),
        .o_job           (front_job)
    );

    // job queue
    bbds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (empty)
    );

    // back: store, sequencer and result register
    bbds_back #(
        .STORE_BYTES(STORE_BYTES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_job    (head_job),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_pixels (o_pixels)
    );

endmodule

/* rtl/bbds_checker.sv */
// bbds_checker: port-level checks of bitmap_box_downscale_threshold
// standalone, attached to the top level by the bind below

module bbds_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_pixels,
    input logic       o_cfg_ready
);

    // a result word waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result word dropped while stalled");

    // stalled result word keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_pixels))
        else $error("result word changed while stalled");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word present after reset");

    // reset empties the job queue so input is open
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready)
        else $error("input not ready after reset");

    // configuration writes are never held off
    a_cfg_ready: assert property (@(posedge i_clk)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind bitmap_box_downscale_threshold bbds_checker u_chk (.*);
